@@ hw/rtl/rce_pkg.sv @@
// Shared types and constants for the rotation compare engine.
package rce_pkg;

    localparam int POS_W      = 20;
    localparam int LEN_W      = 21;
    localparam int BYTE_W     = 8;
    localparam int QUAD_W     = 16;
    localparam int WORD_W     = BYTE_W + QUAD_W;
    localparam int BUD_W      = 32;
    localparam int HEAD_BYTES = 12;
    localparam int GROUP_SIZE = 8;
    localparam int GRP_W      = 18;
    localparam int FIFO_DEPTH = 4;

    localparam int S_TDATA_W  = 120;
    localparam int M_TDATA_W  = 40;

    // input tdata field offsets
    localparam int LD_IDX_LSB  = 0;
    localparam int LD_BYTE_LSB = 20;
    localparam int LD_QUAD_LSB = 28;
    localparam int POS_A_LSB   = 44;
    localparam int POS_B_LSB   = 64;
    localparam int BUD_LSB     = 84;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPARE = 1'b1;

    typedef enum logic {
        K_LOAD,
        K_COMPARE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   addr;
        logic [WORD_W-1:0]  word;   // {quadrant, byte}
        logic [POS_W-1:0]   pos_a;
        logic [POS_W-1:0]   pos_b;
        logic [BUD_W-1:0]   budget;
    } t_cmd;

    typedef struct packed {
        logic               done;
        logic [POS_W-1:0]   pos_a;
        logic [POS_W-1:0]   pos_b;
    } t_mod_res;

endpackage

@@ hw/rtl/rce_front.sv @@
// Input stage: takes stream transfers, decodes them into commands, drops bad loads.
module rce_front
    import rce_pkg::*;
#(
    parameter int MAX_BLOCK = 1048576
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tuser,
    output logic                 o_cmd_vld,
    output t_cmd                 o_cmd,
    input  logic                 i_cmd_rdy
);

    localparam logic [LEN_W-1:0] MaxBlk = LEN_W'(MAX_BLOCK);

    logic r_vld;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic w_take;
    logic w_keep;

    assign o_s_tready = !r_vld || i_cmd_rdy;
    assign w_take     = i_s_tvalid && o_s_tready;
    assign o_cmd_vld  = r_vld;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_cmd.kind   = (i_s_tuser == OP_COMPARE) ? K_COMPARE : K_LOAD;
        n_cmd.addr   = i_s_tdata[LD_IDX_LSB +: POS_W];
        n_cmd.word   = {i_s_tdata[LD_QUAD_LSB +: QUAD_W], i_s_tdata[LD_BYTE_LSB +: BYTE_W]};
        n_cmd.pos_a  = i_s_tdata[POS_A_LSB +: POS_W];
        n_cmd.pos_b  = i_s_tdata[POS_B_LSB +: POS_W];
        n_cmd.budget = i_s_tdata[BUD_LSB +: BUD_W];
        // drop loads that fall outside the store
        w_keep = (n_cmd.kind == K_COMPARE) || ({1'b0, n_cmd.addr} < MaxBlk);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= w_keep;
        end else if (i_cmd_rdy) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

@@ hw/rtl/rce_fifo.sv @@
// Short command queue between the input stage and the compare engine.
module rce_fifo
    import rce_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty
);

    localparam int PtrW = $clog2(FIFO_DEPTH);
    localparam int CntW = $clog2(FIFO_DEPTH + 1);

    t_cmd            r_buf [FIFO_DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_count;

    assign o_full  = (r_count == CntW'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(FIFO_DEPTH))
        else $error("queue fill count beyond depth");
`endif

endmodule

@@ hw/rtl/rce_modu.sv @@
// Bit-serial remainder unit: reduces both start positions modulo the block length.
module rce_modu
    import rce_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [POS_W-1:0] i_pos_a,
    input  logic [POS_W-1:0] i_pos_b,
    input  logic [LEN_W-1:0] i_len,
    output t_mod_res         o_res
);

    localparam int CntW = $clog2(POS_W);

    logic             r_busy;
    logic             r_done;
    logic [CntW-1:0]  r_cnt;
    logic [POS_W-1:0] r_xa;
    logic [POS_W-1:0] r_xb;
    logic [LEN_W-1:0] r_ra;
    logic [LEN_W-1:0] r_rb;
    logic [LEN_W-1:0] n_ra;
    logic [LEN_W-1:0] n_rb;
    logic [LEN_W-1:0] w_ta;
    logic [LEN_W-1:0] w_tb;

    // shift in the next dividend bit, subtract once if it reaches the length
    always_comb begin
        w_ta = {r_ra[POS_W-1:0], r_xa[POS_W-1]};
        w_tb = {r_rb[POS_W-1:0], r_xb[POS_W-1]};
        n_ra = (w_ta >= i_len) ? w_ta - i_len : w_ta;
        n_rb = (w_tb >= i_len) ? w_tb - i_len : w_tb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(POS_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_xa <= i_pos_a;
            r_xb <= i_pos_b;
            r_ra <= '0;
            r_rb <= '0;
        end else if (r_busy) begin
            r_xa <= r_xa << 1;
            r_xb <= r_xb << 1;
            r_ra <= n_ra;
            r_rb <= n_rb;
        end
    end

    assign o_res.done  = r_done;
    assign o_res.pos_a = r_ra[POS_W-1:0];
    assign o_res.pos_b = r_rb[POS_W-1:0];

`ifndef SYNTHESIS
    a_rem_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_ra < i_len) && (r_rb < i_len))
        else $error("remainder not below block length");
`endif

endmodule

@@ hw/rtl/rce_back.sv @@
// Compare engine: symbol store, rotation walk and result register.
module rce_back
    import rce_pkg::*;
#(
    parameter int MAX_BLOCK = 1048576
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [LEN_W-1:0]     i_len,
    input  t_cmd                 i_head,
    input  logic                 i_empty,
    output logic                 o_pop,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    localparam int AW = $clog2(MAX_BLOCK);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_WALK,
        S_OUT
    } t_state;

    t_state            r_state;
    logic [WORD_W-1:0] r_mem [MAX_BLOCK];
    logic [WORD_W-1:0] r_da;
    logic [WORD_W-1:0] r_db;
    logic [AW-1:0]     r_pa;
    logic [AW-1:0]     r_pb;
    logic              r_rv;
    logic              r_in_head;
    logic [3:0]        r_hcnt;
    logic [2:0]        r_gpos;
    logic [GRP_W-1:0]  r_grp_left;
    logic [BUD_W-1:0]  r_budget;
    logic              r_greater;

    logic              w_start;
    logic              w_wr;
    t_mod_res          w_mod;
    logic [BYTE_W-1:0] w_ba;
    logic [BYTE_W-1:0] w_bb;
    logic [QUAD_W-1:0] w_qa;
    logic [QUAD_W-1:0] w_qb;

    function automatic logic [AW-1:0] f_adv(input logic [AW-1:0] pos,
                                            input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] nx;
        nx = LEN_W'(pos) + 1'b1;
        return (nx >= len) ? '0 : pos + 1'b1;
    endfunction

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign w_wr    = o_pop && (i_head.kind == K_LOAD);
    assign w_start = o_pop && (i_head.kind == K_COMPARE);

    assign w_ba = r_da[BYTE_W-1:0];
    assign w_bb = r_db[BYTE_W-1:0];
    assign w_qa = r_da[WORD_W-1:BYTE_W];
    assign w_qb = r_db[WORD_W-1:BYTE_W];

    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = {(M_TDATA_W - BUD_W - 1)'(0), r_budget, r_greater};

    rce_modu u_modu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_pos_a (i_head.pos_a),
        .i_pos_b (i_head.pos_b),
        .i_len   (i_len),
        .o_res   (w_mod)
    );

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[i_head.addr[AW-1:0]] <= i_head.word;
        end
        r_da <= r_mem[r_pa];
        r_db <= r_mem[r_pb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rv    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_budget <= i_head.budget;
                        r_state  <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (w_mod.done) begin
                        r_pa       <= w_mod.pos_a[AW-1:0];
                        r_pb       <= w_mod.pos_b[AW-1:0];
                        r_rv       <= 1'b0;
                        r_in_head  <= 1'b1;
                        r_hcnt     <= '0;
                        r_gpos     <= '0;
                        r_grp_left <= GRP_W'(i_len >> 3) + GRP_W'(2);
                        r_state    <= S_WALK;
                    end
                end
                S_WALK: begin
                    // issue the next pair of reads while checking the last one
                    r_pa <= f_adv(r_pa, i_len);
                    r_pb <= f_adv(r_pb, i_len);
                    r_rv <= 1'b1;
                    if (r_rv) begin
                        if (w_ba != w_bb) begin
                            r_greater <= (w_ba > w_bb);
                            r_rv      <= 1'b0;
                            r_state   <= S_OUT;
                        end else if (!r_in_head && (w_qa != w_qb)) begin
                            r_greater <= (w_qa > w_qb);
                            r_rv      <= 1'b0;
                            r_state   <= S_OUT;
                        end else if (r_in_head) begin
                            if (r_hcnt == 4'(HEAD_BYTES - 1)) begin
                                r_in_head <= 1'b0;
                            end
                            r_hcnt <= r_hcnt + 1'b1;
                        end else begin
                            r_gpos <= r_gpos + 1'b1;
                            if (r_gpos == 3'(GROUP_SIZE - 1)) begin
                                r_budget   <= r_budget - 1'b1;
                                r_grp_left <= r_grp_left - 1'b1;
                                if (r_grp_left == GRP_W'(1)) begin
                                    r_greater <= 1'b0;
                                    r_rv      <= 1'b0;
                                    r_state   <= S_OUT;
                                end
                            end
                        end
                    end
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_walk_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (LEN_W'(r_pa) < i_len) && (LEN_W'(r_pb) < i_len))
        else $error("walk position beyond block length");

    a_budget_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> $stable(r_budget) && $stable(r_greater))
        else $error("result changed while waiting for transfer");
`endif

endmodule

@@ hw/rtl/rotation_compare_engine.sv @@
// Top level of the rotation compare engine.
//
// Input stream s_axis: tuser selects the item kind (0 load, 1 compare). A load
// writes one byte and one quadrant into the store at load_index; loads at or
// beyond MAX_BLOCK are dropped. A compare walks the rotations that start at
// first_pos and second_pos and returns one transfer on m_axis: greater and the
// budget after one decrement per completed group of eight.
// Configuration: i_cfg_we with i_cfg_wdata sets block_length (clamped to
// 1..MAX_BLOCK); write it only while no compare is in flight.
// Compare flow: the compare is popped, then the bit-serial remainder unit reduces
// the start positions, then the walk compares k symbols (one store read pair per
// cycle); k is at most 12 + 8 * (L / 8 + 2).
// A four-entry queue keeps the input side taking transfers while the engine
// works or m_axis stalls; the result holds until m_axis_tready.
// Reset clears the control state and sets block_length to 1; the store is
// not cleared and reads of unwritten entries return unknown data.
module rotation_compare_engine
    import rce_pkg::*;
#(
    parameter int MAX_BLOCK = 1048576
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [LEN_W-1:0]     i_cfg_wdata,    // block_length
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // load_index, load_byte, load_quadrant, first_pos, second_pos, budget_in
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [0:0]           s_axis_tuser,   // op
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // greater, budget_out
);

    localparam logic [LEN_W-1:0] MaxBlk = LEN_W'(MAX_BLOCK);

    logic [LEN_W-1:0] r_len;
    logic             w_cmd_vld;
    t_cmd             w_cmd;
    logic             w_full;
    logic             w_empty;
    logic             w_pop;
    t_cmd             w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_wdata == '0) begin
                r_len <= LEN_W'(1);
            end else if (i_cfg_wdata > MaxBlk) begin
                r_len <= MaxBlk;
            end else begin
                r_len <= i_cfg_wdata;
            end
        end
    end

    rce_front #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser[0]),
        .o_cmd_vld  (w_cmd_vld),
        .o_cmd      (w_cmd),
        .i_cmd_rdy  (!w_full)
    );

    rce_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_vld && !w_full),
        .i_data  (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    rce_back #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_len      (r_len),
        .i_head     (w_head),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule
